### rtl/core/bfbp_pkg.sv
// Shared types and constants of the best-fit buffer pool.
package bfbp_pkg;

  // Entries held by each of the two pools.
  localparam int unsigned POOL_DEPTH  = 16;
  // Bits of a handle kept in storage.
  localparam int unsigned HANDLE_BITS = 16;

  // Fixed field widths of the stream items.
  localparam int unsigned BYTES_W     = 31;
  localparam int unsigned IO_HANDLE_W = 16;

  // Derived widths.
  localparam int unsigned CNT_W     = $clog2(POOL_DEPTH + 1);
  localparam int unsigned IDX_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned MEM_DEPTH = 2 * POOL_DEPTH;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
  localparam int unsigned HEXT_W    = (HANDLE_BITS > IO_HANDLE_W) ? HANDLE_BITS : IO_HANDLE_W;

  // Operation codes.
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_GRANTED = 2'd0,
    STATUS_MISS    = 2'd1,
    STATUS_STORED  = 2'd2,
    STATUS_DROPPED = 2'd3
  } status_e;

  // One stored pool entry.
  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    logic [BYTES_W-1:0]     bytes;
  } entry_t;

  // Controller states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_RELEASE  = 6'b000010,
    S_SCAN     = 6'b000100,
    S_SCAN_END = 6'b001000,
    S_SWAP     = 6'b010000,
    S_DONE     = 6'b100000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic rel_wr;
    logic scan_rd;
    logic last_rd;
    logic swap_wr;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_release;
    logic in_empty;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

### rtl/core/bfbp_ctrl.sv
// Sequencer of the best-fit buffer pool: steps each item through
// release, scan, swap removal and result hand-over.
module bfbp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bfbp_pkg::stat_t stat_i,
  output bfbp_pkg::cmd_t  cmd_o
);

  bfbp_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfbp_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == bfbp_pkg::S_IDLE);

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      bfbp_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          if (stat_i.in_release) begin
            state_d = bfbp_pkg::S_RELEASE;
          end else if (stat_i.in_empty) begin
            state_d = bfbp_pkg::S_SCAN_END;
          end else begin
            state_d = bfbp_pkg::S_SCAN;
          end
        end
      end
      bfbp_pkg::S_RELEASE: begin
        cmd_o.rel_wr = 1'b1;
        state_d      = bfbp_pkg::S_DONE;
      end
      bfbp_pkg::S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.scan_last) begin
          state_d = bfbp_pkg::S_SCAN_END;
        end
      end
      bfbp_pkg::S_SCAN_END: begin
        cmd_o.last_rd = 1'b1;
        state_d       = bfbp_pkg::S_SWAP;
      end
      bfbp_pkg::S_SWAP: begin
        cmd_o.swap_wr = 1'b1;
        state_d       = bfbp_pkg::S_DONE;
      end
      bfbp_pkg::S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = bfbp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bfbp_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/bfbp_datapath.sv
// Datapath of the best-fit buffer pool: entry memory, fill counts,
// best-fit comparator and the output register.
module bfbp_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_op_i,
  input  logic                                in_pool_i,
  input  logic [bfbp_pkg::BYTES_W-1:0]        in_bytes_i,
  input  logic [bfbp_pkg::IO_HANDLE_W-1:0]    in_handle_i,
  input  bfbp_pkg::cmd_t                      cmd_i,
  output bfbp_pkg::stat_t                     stat_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output bfbp_pkg::status_e                   out_status_o,
  output logic [bfbp_pkg::IO_HANDLE_W-1:0]    out_handle_o,
  output logic [bfbp_pkg::BYTES_W-1:0]        out_bytes_o
);

  localparam int unsigned CNT_W  = bfbp_pkg::CNT_W;
  localparam int unsigned IDX_W  = bfbp_pkg::IDX_W;
  localparam int unsigned ADDR_W = bfbp_pkg::ADDR_W;
  localparam int unsigned HEXT_W = bfbp_pkg::HEXT_W;
  localparam int unsigned HB     = bfbp_pkg::HANDLE_BITS;

  // Latched request.
  logic                           op_q;
  logic                           pool_q;
  logic [bfbp_pkg::BYTES_W-1:0]   size_q;
  logic [HB-1:0]                  handle_q;

  // Fill counts of the two pools.
  logic [CNT_W-1:0]               cnt_q [2];
  logic [CNT_W-1:0]               cur_cnt;
  logic [CNT_W-1:0]               last_cnt;

  // Scan and compare.
  logic [CNT_W-1:0]               scan_q;
  logic                           cmp_vld_q;
  logic [IDX_W-1:0]               cmp_idx_q;
  logic                           found_q;
  logic [IDX_W-1:0]               best_idx_q;
  logic [bfbp_pkg::BYTES_W-1:0]   best_bytes_q;
  logic [HB-1:0]                  best_handle_q;
  bfbp_pkg::status_e              status_q;

  // Entry memory.
  bfbp_pkg::entry_t               mem [bfbp_pkg::MEM_DEPTH];
  bfbp_pkg::entry_t               rd_q;
  bfbp_pkg::entry_t               wr_data;
  logic                           rd_en;
  logic                           wr_en;
  logic [ADDR_W-1:0]              base;
  logic [ADDR_W-1:0]              rd_addr;
  logic [ADDR_W-1:0]              wr_addr;
  logic                           pool_full;
  logic                           better;

  // Handle width conversion.
  logic [HEXT_W-1:0]              in_handle_ext;
  logic [HEXT_W-1:0]              best_handle_ext;

  // Output register.
  logic                           out_valid_q;
  bfbp_pkg::status_e              out_status_q;
  logic [bfbp_pkg::IO_HANDLE_W-1:0] out_handle_q;
  logic [bfbp_pkg::BYTES_W-1:0]   out_bytes_q;

  assign in_handle_ext   = HEXT_W'(in_handle_i);
  assign best_handle_ext = HEXT_W'(best_handle_q);

  assign cur_cnt   = cnt_q[pool_q];
  assign last_cnt  = CNT_W'(cur_cnt - CNT_W'(1));
  assign pool_full = (cur_cnt == CNT_W'(bfbp_pkg::POOL_DEPTH));
  assign base      = pool_q ? ADDR_W'(bfbp_pkg::POOL_DEPTH) : '0;

  // Status towards the controller.
  assign stat_o.in_release = (in_op_i == bfbp_pkg::OP_RELEASE);
  assign stat_o.in_empty   = (cnt_q[in_pool_i] == '0);
  assign stat_o.scan_last  = (scan_q == last_cnt);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // Memory port addressing.
  always_comb begin
    rd_en   = cmd_i.scan_rd || (cmd_i.last_rd && (cur_cnt != '0));
    rd_addr = cmd_i.scan_rd ? ADDR_W'(base + ADDR_W'(scan_q[IDX_W-1:0]))
                            : ADDR_W'(base + ADDR_W'(last_cnt[IDX_W-1:0]));
    wr_en   = (cmd_i.rel_wr && !pool_full) || (cmd_i.swap_wr && found_q);
    if (cmd_i.rel_wr) begin
      wr_addr        = ADDR_W'(base + ADDR_W'(cur_cnt[IDX_W-1:0]));
      wr_data.handle = handle_q;
      wr_data.bytes  = size_q;
    end else begin
      wr_addr = ADDR_W'(base + ADDR_W'(best_idx_q));
      wr_data = rd_q;
    end
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // An entry beats the best so far if it fits and is strictly smaller.
  assign better = cmp_vld_q && (rd_q.bytes >= size_q) &&
                  (!found_q || (rd_q.bytes < best_bytes_q));

  // Control registers: counts, scan position and compare flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q[0]  <= '0;
      cnt_q[1]  <= '0;
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
      found_q   <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan_rd;
      if (cmd_i.latch) begin
        scan_q  <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) begin
          scan_q <= CNT_W'(scan_q + CNT_W'(1));
        end
        if (better) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.rel_wr && !pool_full) begin
        cnt_q[pool_q] <= CNT_W'(cur_cnt + CNT_W'(1));
      end else if (cmd_i.swap_wr && found_q) begin
        cnt_q[pool_q] <= last_cnt;
      end
    end
  end

  // Payload registers: request, best candidate and status.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q     <= in_op_i;
      pool_q   <= in_pool_i;
      size_q   <= in_bytes_i;
      handle_q <= in_handle_ext[HB-1:0];
    end
    cmp_idx_q <= scan_q[IDX_W-1:0];
    if (better) begin
      best_idx_q    <= cmp_idx_q;
      best_bytes_q  <= rd_q.bytes;
      best_handle_q <= rd_q.handle;
    end
    if (cmd_i.rel_wr) begin
      status_q <= pool_full ? bfbp_pkg::STATUS_DROPPED : bfbp_pkg::STATUS_STORED;
    end else if (cmd_i.swap_wr) begin
      status_q <= found_q ? bfbp_pkg::STATUS_GRANTED : bfbp_pkg::STATUS_MISS;
    end
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload; only a grant carries a handle and a size.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= status_q;
      if ((op_q == bfbp_pkg::OP_ALLOC) && (status_q == bfbp_pkg::STATUS_GRANTED)) begin
        out_handle_q <= best_handle_ext[bfbp_pkg::IO_HANDLE_W-1:0];
        out_bytes_q  <= best_bytes_q;
      end else begin
        out_handle_q <= '0;
        out_bytes_q  <= '0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_handle_o = out_handle_q;
  assign out_bytes_o  = out_bytes_q;

endmodule

### rtl/core/best_fit_buffer_pool.sv
// Best-fit buffer pool: keeps released index and vertex buffers in two
// pools and hands back the smallest pooled buffer that is large enough.
//
// The slave stream carries requests: tuser holds the operation (allocate or
// release) and the pool, tdata the byte size and, on a release, the handle.
// The master stream returns exactly one item per request: tuser holds the
// status, tdata the granted handle and size (zero unless granted).
//
// One item is in work at a time. A release writes its entry in the release
// state and loads its result into the output register in the done state.
// An allocate reads the pool's filled entries through the single memory read
// port, one per cycle, then reads the last entry, on a grant moves it into
// the granted slot, and loads its result in the done state; the next item is
// taken once the result has been loaded.
//
// After reset both pools are empty and no result is pending. When the
// receiver stalls, the result waits in the output register; the block may
// take one more item and works it up to its result, then holds that result
// until the output register is free.
module best_fit_buffer_pool (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // byte_size[30:0], buffer_handle[46:31], zero pad
  input  logic [1:0]  s_axis_tuser,  // op[0], pool[1]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // granted_handle[15:0], granted_bytes[46:16], zero pad
  output logic [1:0]  m_axis_tuser   // status[1:0]
);

  bfbp_pkg::cmd_t    cmd;
  bfbp_pkg::stat_t   stat;
  bfbp_pkg::status_e out_status;
  logic [bfbp_pkg::IO_HANDLE_W-1:0] out_handle;
  logic [bfbp_pkg::BYTES_W-1:0]     out_bytes;

  // Sequencer.
  bfbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Storage, comparator and output register.
  bfbp_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_op_i      (s_axis_tuser[0]),
    .in_pool_i    (s_axis_tuser[1]),
    .in_bytes_i   (s_axis_tdata[30:0]),
    .in_handle_i  (s_axis_tdata[46:31]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_handle_o (out_handle),
    .out_bytes_o  (out_bytes)
  );

  assign m_axis_tdata = {1'b0, out_bytes, out_handle};
  assign m_axis_tuser = out_status;

endmodule

### rtl/core/bfbp_checker.sv
// Port-level checks of the best-fit buffer pool.
module bfbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result payload changed while stalled");

  // Only one item is taken at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while another is in work");

  // A result never appears in the cycle right after an item is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
    else $error("result appeared too early");

  // Only a grant carries a handle and a size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != bfbp_pkg::STATUS_GRANTED)) |-> (m_axis_tdata == '0))
    else $error("non-grant result carries data");

  // A release never answers with an allocate status on an idle block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser[0] && !m_axis_tvalid) |=> ##2
      (m_axis_tvalid && ((m_axis_tuser == bfbp_pkg::STATUS_STORED) ||
                         (m_axis_tuser == bfbp_pkg::STATUS_DROPPED))))
    else $error("release result missing or wrong");

endmodule

bind best_fit_buffer_pool bfbp_checker u_bfbp_checker (.*);

### verif/best_fit_buffer_pool_test.sv
`timescale 1ns / 1ps

module best_fit_buffer_pool_test;
  import bfbp_pkg::*;

  // Pool selectors as carried in the request tuser.
  localparam logic POOL_INDEX  = 1'b0;
  localparam logic POOL_VERTEX = 1'b1;

  localparam logic [BYTES_W-1:0]     BYTES_MAX  = {BYTES_W{1'b1}};
  localparam logic [IO_HANDLE_W-1:0] HANDLE_MAX = {IO_HANDLE_W{1'b1}};

  // Cycles without any accepted item or result before the run is declared hung.
  localparam int unsigned HANG_LIMIT    = 4000;
  // Settling time after the last result: a full-pool allocate plus margin.
  localparam int unsigned SETTLE_CYCLES = 2 * POOL_DEPTH + 8;
  localparam int unsigned RANDOM_PHASES = 14;
  localparam int unsigned PHASE_ITEMS   = 100;

  typedef struct {
    status_e                status;
    logic [IO_HANDLE_W-1:0] handle;
    logic [BYTES_W-1:0]     bytes;
  } pool_result_t;

  typedef struct {
    logic                   op;
    logic                   pool;
    logic [BYTES_W-1:0]     bytes;
    logic [IO_HANDLE_W-1:0] handle;
    int unsigned            reps;
    bit                     known;
    pool_result_t           result;
  } stim_row_t;

  // A typed expectation travelling alongside the item it belongs to.
  typedef struct {
    bit           known;
    pool_result_t result;
  } row_note_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // byte_size[30:0], buffer_handle[46:31], zero pad
  logic [1:0]  s_axis_tuser = '0;  // op[0], pool[1]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;       // granted_handle[15:0], granted_bytes[46:16], zero pad
  logic [1:0]  m_axis_tuser;       // status[1:0]

  // Predicted contents of both pools.
  logic [BYTES_W-1:0]     pool_bytes   [2][POOL_DEPTH];
  logic [HANDLE_BITS-1:0] pool_handles [2][POOL_DEPTH];
  int unsigned            pool_fill    [2] = '{0, 0};

  pool_result_t expected_results[$];
  row_note_t    row_notes[$];
  stim_row_t    stim_rows[$];

  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  bit          quiet = 1'b0;

  best_fit_buffer_pool u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  function automatic pool_result_t make_result(input status_e status,
                                               input logic [IO_HANDLE_W-1:0] handle,
                                               input logic [BYTES_W-1:0] bytes);
    pool_result_t res;
    res.status = status;
    res.handle = handle;
    res.bytes  = bytes;
    return res;
  endfunction

  // Applies one request to the predicted pools and returns the answer it earns.
  function automatic pool_result_t predict_pool_op(input logic op, input logic pool,
                                                   input logic [BYTES_W-1:0] size,
                                                   input logic [IO_HANDLE_W-1:0] handle);
    pool_result_t res;
    int unsigned  fill;
    int unsigned  best;
    int unsigned  slot;
    bit           found;
    fill  = pool_fill[pool];
    res   = make_result(STATUS_MISS, '0, '0);
    found = 1'b0;
    best  = 0;
    if (op == OP_RELEASE) begin
      if (fill >= POOL_DEPTH) begin
        res.status = STATUS_DROPPED;
      end else begin
        pool_bytes[pool][fill]   = size;
        pool_handles[pool][fill] = HANDLE_BITS'(handle);
        pool_fill[pool]          = fill + 1;
        res.status               = STATUS_STORED;
      end
    end else begin
      // Smallest entry that fits; strict compare keeps the lowest slot on a tie.
      for (slot = 0; slot < fill; slot++) begin
        if (pool_bytes[pool][slot] >= size &&
            (!found || pool_bytes[pool][slot] < pool_bytes[pool][best])) begin
          found = 1'b1;
          best  = slot;
        end
      end
      if (found) begin
        res.status = STATUS_GRANTED;
        res.handle = IO_HANDLE_W'(pool_handles[pool][best]);
        res.bytes  = pool_bytes[pool][best];
        // The last entry fills the hole left by the granted one.
        pool_bytes[pool][best]   = pool_bytes[pool][fill-1];
        pool_handles[pool][best] = pool_handles[pool][fill-1];
        pool_fill[pool]          = fill - 1;
      end
    end
    return res;
  endfunction

  // Mostly short gaps, now and then a long one; none at all in quiet stretches.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end else if (roll < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: result %0d: %s", $realtime, results_seen, msg);
    mismatches++;
  endtask

  task automatic add_row(input logic op, input logic pool, input logic [BYTES_W-1:0] bytes,
                         input logic [IO_HANDLE_W-1:0] handle, input int unsigned reps,
                         input bit known, input status_e status,
                         input logic [IO_HANDLE_W-1:0] exp_handle,
                         input logic [BYTES_W-1:0] exp_bytes);
    stim_row_t row;
    row.op     = op;
    row.pool   = pool;
    row.bytes  = bytes;
    row.handle = handle;
    row.reps   = reps;
    row.known  = known;
    row.result = make_result(status, exp_handle, exp_bytes);
    stim_rows.push_back(row);
  endtask

  // Offers one item after a random gap and returns once it has been taken.
  task automatic send_item(input logic op, input logic pool, input logic [BYTES_W-1:0] size,
                           input logic [IO_HANDLE_W-1:0] handle, input bit known,
                           input pool_result_t result);
    row_note_t   note;
    int unsigned gap;
    gap         = pick_gap();
    note.known  = known;
    note.result = result;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    row_notes.push_back(note);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {pool, op};
    s_axis_tdata  <= {1'b0, handle, size};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // A random request, steered so that pools fill up, drain and see near fits.
  task automatic send_random_item(input int unsigned mode);
    logic                   op;
    logic                   pool;
    logic [BYTES_W-1:0]     size;
    logic [IO_HANDLE_W-1:0] handle;
    int unsigned            roll;
    int unsigned            release_pct;
    release_pct = (mode == 0) ? 70 : (mode == 1) ? 30 : 50;
    op   = ($urandom_range(0, 99) < release_pct) ? OP_RELEASE : OP_ALLOC;
    pool = $urandom_range(0, 1) ? POOL_VERTEX : POOL_INDEX;
    if ($urandom_range(0, 9) == 0) begin
      handle = $urandom_range(0, 1) ? HANDLE_MAX : '0;
    end else begin
      handle = IO_HANDLE_W'($urandom);
    end
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      size = BYTES_W'($urandom_range(0, 63));
    end else if (roll < 65 && op == OP_ALLOC && pool_fill[pool] != 0) begin
      // Ask for exactly a stored size, or one byte more.
      size = pool_bytes[pool][$urandom_range(0, pool_fill[pool] - 1)];
      if ($urandom_range(0, 1) == 1 && size != BYTES_MAX) begin
        size = size + 1'b1;
      end
    end else if (roll < 85) begin
      size = BYTES_W'($urandom);
    end else if (roll < 93) begin
      size = '0;
    end else begin
      size = BYTES_MAX;
    end
    send_item(op, pool, size, handle, 1'b0, make_result(STATUS_MISS, '0, '0));
  endtask

  // Holds the sender back until every outstanding result has come.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Receiver side: random stalls of varied length.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      stall_left    <= pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Checks each returned item and predicts each accepted request.
  always @(posedge clk_i) begin : monitor
    pool_result_t got;
    pool_result_t want;
    pool_result_t predicted;
    row_note_t    note;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = status_e'(m_axis_tuser);
        got.handle = m_axis_tdata[IO_HANDLE_W-1:0];
        got.bytes  = m_axis_tdata[IO_HANDLE_W +: BYTES_W];
        results_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result, status %s", got.status.name()));
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            report_mismatch($sformatf("status %s, expected %s",
                                      got.status.name(), want.status.name()));
          end
          if (got.handle !== want.handle) begin
            report_mismatch($sformatf("granted_handle 0x%h, expected 0x%h",
                                      got.handle, want.handle));
          end
          if (got.bytes !== want.bytes) begin
            report_mismatch($sformatf("granted_bytes %0d, expected %0d",
                                      got.bytes, want.bytes));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = predict_pool_op(s_axis_tuser[0], s_axis_tuser[1],
                                    s_axis_tdata[BYTES_W-1:0],
                                    s_axis_tdata[BYTES_W +: IO_HANDLE_W]);
        note.known = 1'b0;
        if (row_notes.size() != 0) begin
          note = row_notes.pop_front();
        end
        expected_results.push_back(note.known ? note.result : predicted);
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned n;

    // Directed requests: empty pools, ties, extremes and a full pool.
    add_row(OP_ALLOC, POOL_INDEX, '0, HANDLE_MAX, 1, 1'b1, STATUS_MISS, '0, '0);
    add_row(OP_ALLOC, POOL_VERTEX, BYTES_MAX, '0, 1, 1'b1, STATUS_MISS, '0, '0);
    add_row(OP_RELEASE, POOL_INDEX, 31'd100, 16'h0001, 1, 1'b1, STATUS_STORED, '0, '0);
    add_row(OP_RELEASE, POOL_INDEX, 31'd50, 16'h0002, 1, 1'b1, STATUS_STORED, '0, '0);
    add_row(OP_RELEASE, POOL_INDEX, 31'd50, 16'h0003, 1, 1'b1, STATUS_STORED, '0, '0);
    add_row(OP_RELEASE, POOL_INDEX, BYTES_MAX, HANDLE_MAX, 1, 1'b1, STATUS_STORED, '0, '0);
    // A zero-byte request takes the smallest entry, the lower of two equal ones.
    add_row(OP_ALLOC, POOL_INDEX, '0, HANDLE_MAX, 1, 1'b1, STATUS_GRANTED, 16'h0002, 31'd50);
    add_row(OP_ALLOC, POOL_INDEX, 31'd51, '0, 1, 1'b0, STATUS_MISS, '0, '0);
    add_row(OP_ALLOC, POOL_INDEX, BYTES_MAX, '0, 1, 1'b1, STATUS_GRANTED, HANDLE_MAX,
            BYTES_MAX);
    add_row(OP_ALLOC, POOL_INDEX, 31'd51, '0, 1, 1'b0, STATUS_MISS, '0, '0);
    add_row(OP_ALLOC, POOL_INDEX, 31'd50, '0, 1, 1'b0, STATUS_MISS, '0, '0);
    // Fill the vertex pool, then overflow it.
    add_row(OP_RELEASE, POOL_VERTEX, '0, '0, POOL_DEPTH, 1'b1, STATUS_STORED, '0, '0);
    add_row(OP_RELEASE, POOL_VERTEX, BYTES_MAX, HANDLE_MAX, 1, 1'b1, STATUS_DROPPED, '0, '0);
    add_row(OP_ALLOC, POOL_VERTEX, 31'd1, '0, 1, 1'b1, STATUS_MISS, '0, '0);
    add_row(OP_ALLOC, POOL_VERTEX, '0, '0, 1, 1'b1, STATUS_GRANTED, '0, '0);
    add_row(OP_RELEASE, POOL_VERTEX, 31'h2AAA_AAAA, 16'hA5A5, 1, 1'b0, STATUS_MISS, '0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_rows[r]) begin
      for (n = 0; n < stim_rows[r].reps; n++) begin
        send_item(stim_rows[r].op, stim_rows[r].pool, stim_rows[r].bytes,
                  stim_rows[r].handle, stim_rows[r].known, stim_rows[r].result);
      end
    end
    wait_for_results();

    // Random phases rotate between release-heavy, allocate-heavy and balanced mixes.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      quiet = (phase == 4 || phase == 9);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_random_item(phase % 3);
      end
      if (phase == 6) begin
        wait_for_results();
      end
    end
    quiet = 1'b0;

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/bfbp_pkg.sv
rtl/core/bfbp_ctrl.sv
rtl/core/bfbp_datapath.sv
rtl/core/best_fit_buffer_pool.sv
rtl/core/bfbp_checker.sv
verif/best_fit_buffer_pool_test.sv
